FILE: hdl/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWA,
        S_SWB
    } t_state;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_SWEEP = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int         START_W   = 16;
    localparam int         LEN_W     = 17;
    localparam int         SEG_W     = START_W + LEN_W;

    localparam logic [LEN_W-1:0] HEAP_MAX = 17'd65536;

endpackage

FILE: hdl/ffa_ram.sv
`timescale 1ns / 1ps

module ffa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/first_fit_allocator_with_sweep_top.sv
`timescale 1ns / 1ps

// First-fit heap allocator with a sweep that rebuilds its free-segment table. Raise start
// with a word while busy is low; exactly one result word follows, shown for one cycle with
// o_done high, and the receiver cannot stall it. An allocation reads the segment memory
// one entry per cycle, newest slot first, and stops at the first fitting segment or after
// the oldest slot with no fit. A sweep word passes through S_SWA, which records a segment
// when a live word ends a free run, then with last set S_SWB, writing the last run to the
// segment memory. busy stays high until the result is registered, so words are handled one
// at a time; the next word can be accepted at the edge that ends the o_done cycle.
// heap_bytes is written through the configuration channel, which is always ready; write it
// only while the block is idle.
module first_fit_allocator_with_sweep_top #(
    parameter int TABLE_DEPTH  = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [16:0] i_object_size,
    input  logic        i_marked,
    input  logic        i_last,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_address,
    output logic [16:0] o_freed_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    import ffa_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam logic [LEN_W:0] HDR = (LEN_W + 1)'(HEADER_BYTES);

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_heap_bytes;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [SW-1:0]         r_slot, n_slot;
    logic [LEN_W-1:0]      r_walk, n_walk;
    logic [LEN_W-1:0]      r_pend, n_pend;
    logic [LEN_W-1:0]      r_recl, n_recl;
    logic                  r_sweep_busy, n_sweep_busy;
    logic [AW-1:0]         r_idx, n_idx;
    logic [LEN_W-1:0]      r_size, n_size;
    logic                  r_marked, n_marked;
    logic                  r_last, n_last;
    logic [1:0]            r_sw_status, n_sw_status;

    logic                  r_done, n_done;
    logic [1:0]            r_status, n_status;
    logic [START_W-1:0]    r_address, n_address;
    logic [LEN_W-1:0]      r_freed, n_freed;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [SEG_W-1:0]      wdata;
    logic [AW-1:0]         raddr;
    logic [SEG_W-1:0]      rdata;

    logic [START_W-1:0]    seg_start;
    logic [LEN_W-1:0]      seg_len;
    logic [LEN_W-1:0]      heap;

    logic [LEN_W-1:0]      walk0, pend0, recl0, whole, room, rest, fin_len;
    logic [SW-1:0]         slot0;
    logic [LEN_W:0]        whole_raw, recl_sum;
    logic                  in_heap;
    logic                  accept;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign seg_start = rdata[SEG_W-1:LEN_W];
    assign seg_len   = rdata[LEN_W-1:0];
    assign heap      = (r_heap_bytes > HEAP_MAX) ? HEAP_MAX : r_heap_bytes;

    assign raddr = (r_state == S_IDLE) ? AW'(TABLE_DEPTH - 1) : r_idx - 1'b1;

    ffa_ram #(
        .WIDTH (SEG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // header step operands, taken from zero on the first word of a sweep
    always_comb begin
        walk0 = r_sweep_busy ? r_walk : '0;
        pend0 = r_sweep_busy ? r_pend : '0;
        recl0 = r_sweep_busy ? r_recl : '0;
        slot0 = r_sweep_busy ? r_slot : '0;
        in_heap   = (({1'b0, walk0} + HDR) < {1'b0, heap});
        whole_raw = {1'b0, r_size} + HDR;
        room      = heap - walk0;
        whole     = (whole_raw > {1'b0, room}) ? room : whole_raw[LEN_W-1:0];
        rest      = (r_walk < heap) ? heap - r_walk : '0;
        fin_len   = r_pend + rest;
        recl_sum  = {1'b0, r_recl} + {1'b0, r_pend};
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_slot       = r_slot;
        n_walk       = r_walk;
        n_pend       = r_pend;
        n_recl       = r_recl;
        n_sweep_busy = r_sweep_busy;
        n_idx        = r_idx;
        n_size       = r_size;
        n_marked     = r_marked;
        n_last       = r_last;
        n_sw_status  = r_sw_status;
        n_done       = 1'b0;
        n_status     = r_status;
        n_address    = r_address;
        n_freed      = r_freed;
        we           = 1'b0;
        waddr        = r_idx;
        wdata        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_size      = i_object_size;
                    n_marked    = i_marked;
                    n_last      = i_last;
                    n_idx       = AW'(TABLE_DEPTH - 1);
                    n_sw_status = ST_OK;
                    n_state     = (i_cmd == CMD_ALLOC) ? S_SCAN : S_SWA;
                end
            end
            S_SCAN: begin
                n_idx = r_idx - 1'b1;
                if (r_valid[r_idx] && (seg_len == r_size)) begin
                    n_valid[r_idx] = 1'b0;
                    n_done    = 1'b1;
                    n_status  = ST_OK;
                    n_address = seg_start;
                    n_freed   = '0;
                    n_state   = S_IDLE;
                end else if (r_valid[r_idx] && (seg_len > r_size)) begin
                    we        = 1'b1;
                    waddr     = r_idx;
                    wdata     = {seg_start + r_size[START_W-1:0], seg_len - r_size};
                    n_done    = 1'b1;
                    n_status  = ST_OK;
                    n_address = seg_start;
                    n_freed   = '0;
                    n_state   = S_IDLE;
                end else if (r_idx == '0) begin
                    n_done    = 1'b1;
                    n_status  = ST_NOFIT;
                    n_address = '0;
                    n_freed   = '0;
                    n_state   = S_IDLE;
                end
            end
            S_SWA: begin
                if (!r_sweep_busy) begin
                    n_valid = '0;
                end
                n_sweep_busy = 1'b1;
                n_walk = walk0;
                n_pend = pend0;
                n_recl = recl0;
                n_slot = slot0;
                if (in_heap) begin
                    n_walk = walk0 + whole;
                    if (!r_marked) begin
                        n_pend = pend0 + whole;
                    end else begin
                        n_pend = '0;
                        n_recl = recl0 + pend0;
                        if (pend0 != '0) begin
                            if (slot0 < SW'(TABLE_DEPTH)) begin
                                we     = 1'b1;
                                waddr  = slot0[AW-1:0];
                                wdata  = {walk0[START_W-1:0] - pend0[START_W-1:0], pend0};
                                n_valid[slot0[AW-1:0]] = 1'b1;
                                n_slot = slot0 + 1'b1;
                            end else begin
                                n_sw_status = ST_FULL;
                            end
                        end
                    end
                end
                if (r_last) begin
                    n_state = S_SWB;
                end else begin
                    n_done    = 1'b1;
                    n_status  = n_sw_status;
                    n_address = '0;
                    n_freed   = '0;
                    n_state   = S_IDLE;
                end
            end
            S_SWB: begin
                n_status = r_sw_status;
                if (fin_len != '0) begin
                    if (r_slot < SW'(TABLE_DEPTH)) begin
                        we     = 1'b1;
                        waddr  = r_slot[AW-1:0];
                        wdata  = {r_walk[START_W-1:0] - r_pend[START_W-1:0], fin_len};
                        n_valid[r_slot[AW-1:0]] = 1'b1;
                        n_slot = r_slot + 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                n_recl       = (recl_sum > {1'b0, HEAP_MAX}) ? HEAP_MAX
                                                              : recl_sum[LEN_W-1:0];
                n_pend       = '0;
                n_sweep_busy = 1'b0;
                n_done       = 1'b1;
                n_address    = '0;
                n_freed      = n_recl;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_bytes <= HEAP_MAX;
            r_valid      <= '0;
            r_slot       <= '0;
            r_walk       <= '0;
            r_pend       <= '0;
            r_recl       <= '0;
            r_sweep_busy <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_bytes <= i_cfg_data;
            end
            r_valid      <= n_valid;
            r_slot       <= n_slot;
            r_walk       <= n_walk;
            r_pend       <= n_pend;
            r_recl       <= n_recl;
            r_sweep_busy <= n_sweep_busy;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_size      <= n_size;
        r_marked    <= n_marked;
        r_last      <= n_last;
        r_sw_status <= n_sw_status;
        r_status    <= n_status;
        r_address   <= n_address;
        r_freed     <= n_freed;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_address     = r_address;
    assign o_freed_total = r_freed;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result word without an item in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(TABLE_DEPTH))
        else $error("segment slot counter past table depth");

    a_full_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_address == '0))
        else $error("failed word carries an address");

    a_freed_sweep_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_freed_total != '0)) |-> $past(r_state == S_SWB))
        else $error("freed total outside a last sweep word");
`endif

endmodule

FILE: test/first_fit_allocator_with_sweep_top_tb.sv
`timescale 1ns / 1ps

module first_fit_allocator_with_sweep_top_tb;

    import ffa_pkg::*;

    localparam int SLOTS      = 16;
    localparam int HDR_BYTES  = 8;
    localparam int STALL_MAX  = 4000;
    localparam int PHASE_SIZE = 75;

    typedef struct packed {
        logic        cmd;
        logic [16:0] size;
        logic        marked;
        logic        last;
    } t_req_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] address;
        logic [16:0] freed;
    } t_outcome;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        i_cmd         = CMD_ALLOC;
    logic [16:0] i_object_size = '0;
    logic        i_marked      = 1'b0;
    logic        i_last        = 1'b0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_address;
    logic [16:0] o_freed_total;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data    = '0;

    first_fit_allocator_with_sweep_top #(
        .TABLE_DEPTH (SLOTS),
        .HEADER_BYTES(HDR_BYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_object_size(i_object_size),
        .i_marked     (i_marked),
        .i_last       (i_last),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_address    (o_address),
        .o_freed_total(o_freed_total),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // free-segment table as the block should hold it
    logic [15:0] seg_start [SLOTS];
    logic [16:0] seg_len   [SLOTS];
    logic        seg_valid [SLOTS] = '{default: 1'b0};
    int unsigned slot_next  = 0;
    int unsigned walk       = 0;
    int unsigned pend_run   = 0;
    int unsigned reclaimed  = 0;
    logic        in_sweep   = 1'b0;
    logic [16:0] heap_cfg   = 17'd65536;

    t_req_word words_to_send [$];
    t_outcome  outcomes_due  [$];
    t_req_word cur_word;
    int        hold_cycles   = 0;
    logic      no_idle       = 1'b0;
    int        stall_cycles  = 0;
    int        fault_count   = 0;
    int        n_alloc       = 0;
    int        n_sweep_words = 0;
    int        n_sweeps      = 0;
    int        n_full        = 0;
    int        n_nofit       = 0;
    int        n_heaps       = 0;

    function automatic logic store_run(input int unsigned base, input int unsigned len);
        if (len == 0)
            return 1'b1;
        if (slot_next >= SLOTS)
            return 1'b0;
        seg_start[slot_next] = 16'(base);
        seg_len[slot_next]   = 17'(len);
        seg_valid[slot_next] = 1'b1;
        slot_next++;
        return 1'b1;
    endfunction

    function automatic t_outcome predict_outcome(input t_req_word w);
        t_outcome    r;
        int unsigned heap, whole, room, rest;
        logic        hit;
        r   = '{status: ST_OK, address: '0, freed: '0};
        hit = 1'b0;
        if (w.cmd == CMD_ALLOC) begin
            r.status = ST_NOFIT;
            // newest slot first
            for (int k = SLOTS - 1; k >= 0; k--) begin
                if (!hit && seg_valid[k]) begin
                    if (seg_len[k] == w.size) begin
                        r.address    = seg_start[k];
                        r.status     = ST_OK;
                        seg_valid[k] = 1'b0;
                        hit          = 1'b1;
                    end else if (seg_len[k] > w.size) begin
                        r.address    = seg_start[k];
                        r.status     = ST_OK;
                        seg_start[k] = 16'(seg_start[k] + w.size);
                        seg_len[k]   = seg_len[k] - w.size;
                        hit          = 1'b1;
                    end
                end
            end
        end else begin
            heap = (heap_cfg > HEAP_MAX) ? HEAP_MAX : heap_cfg;
            if (!in_sweep) begin
                for (int k = 0; k < SLOTS; k++)
                    seg_valid[k] = 1'b0;
                slot_next = 0;
                walk      = 0;
                pend_run  = 0;
                reclaimed = 0;
                in_sweep  = 1'b1;
            end
            if (walk + HDR_BYTES < heap) begin
                whole = w.size + HDR_BYTES;
                room  = heap - walk;
                if (whole > room)
                    whole = room;
                if (!w.marked) begin
                    pend_run += whole;
                end else begin
                    if (!store_run(walk - pend_run, pend_run))
                        r.status = ST_FULL;
                    reclaimed += pend_run;
                    pend_run = 0;
                end
                walk += whole;
            end
            if (w.last) begin
                rest = (walk < heap) ? heap - walk : 0;
                if (!store_run(walk - pend_run, pend_run + rest))
                    r.status = ST_FULL;
                reclaimed += pend_run;
                if (reclaimed > HEAP_MAX)
                    reclaimed = HEAP_MAX;
                r.freed  = 17'(reclaimed);
                pend_run = 0;
                in_sweep = 1'b0;
            end
        end
        return r;
    endfunction

    // word driver
    always @(posedge i_clk) begin : drive_words
        t_outcome due;
        if (!i_rst_n) begin
            start       <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (start && !busy) begin
                due = predict_outcome(cur_word);
                outcomes_due.push_back(due);
                if (cur_word.cmd == CMD_ALLOC)
                    n_alloc++;
                else
                    n_sweep_words++;
                if (cur_word.cmd == CMD_SWEEP && cur_word.last)
                    n_sweeps++;
                if (due.status == ST_FULL)
                    n_full++;
                if (due.status == ST_NOFIT)
                    n_nofit++;
            end
            if (!(start && busy)) begin
                if (hold_cycles != 0) begin
                    start       <= 1'b0;
                    hold_cycles <= hold_cycles - 1;
                end else if (words_to_send.size() != 0) begin
                    cur_word = words_to_send.pop_front();
                    i_cmd         <= cur_word.cmd;
                    i_object_size <= cur_word.size;
                    i_marked      <= cur_word.marked;
                    i_last        <= cur_word.last;
                    start         <= 1'b1;
                    hold_cycles   <= no_idle ? 0 : $urandom_range(0, 9);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d address %0d freed %0d",
                             o_status, o_address, o_freed_total);
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status || o_address !== want.address ||
                    o_freed_total !== want.freed) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: status %0d/%0d address %0d/%0d freed %0d/%0d",
                                 want.status, o_status, want.address, o_address,
                                 want.freed, o_freed_total);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("timeout: no word moved for %0d cycles", STALL_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (words_to_send.size() != 0 || outcomes_due.size() != 0 || start || busy);
    endtask

    task automatic set_heap(input logic [16:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        heap_cfg = v;
        n_heaps++;
        @(negedge i_clk);
    endtask

    task automatic push_word(input logic cmd, input logic [16:0] size,
                             input logic marked, input logic last);
        words_to_send.push_back('{cmd: cmd, size: size, marked: marked, last: last});
    endtask

    function automatic logic [16:0] pick_size(input int unsigned heap);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 17'($urandom_range(0, 65536));
        if (r == 1)
            return '0;
        if (r <= 5)
            return 17'($urandom_range(0, 32));
        return 17'($urandom_range(0, heap / 8));
    endfunction

    task automatic queue_phase(input int unsigned heap, input int quota);
        int   made, n, style;
        logic broken;
        made = 0;
        while (made < quota) begin
            if ($urandom_range(0, 4) < 2) begin
                // sweep walk; comb style alternates garbage and live to fill the table
                style  = $urandom_range(0, 3);
                n      = (style == 0) ? $urandom_range(34, 48) : $urandom_range(1, 24);
                broken = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_word(CMD_ALLOC, pick_size(heap), 1'b0, 1'b0);
                        made++;
                    end
                    if (style == 0)
                        push_word(CMD_SWEEP, 17'($urandom_range(0, 24)), i[0],
                                  (i == n - 1) && !broken);
                    else
                        push_word(CMD_SWEEP, pick_size(heap), 1'($urandom_range(0, 1)),
                                  (i == n - 1) && !broken);
                    made++;
                end
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    push_word(CMD_ALLOC, pick_size(heap), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    made++;
                end
            end
        end
    endtask

    initial begin
        logic [16:0] heaps [7];
        int unsigned eff;
        heaps = '{17'd16, 17'd131071, 17'd1000, 17'd65536, 17'd0, 17'd300, 17'd4096};
        heaps[4] = 17'($urandom_range(16, 65536));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_heap(17'd65536);

        push_word(CMD_ALLOC, 17'd0, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd20, 1'b1, 1'b0);
        push_word(CMD_SWEEP, 17'd100, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd0, 1'b1, 1'b0);
        push_word(CMD_SWEEP, 17'd30, 1'b1, 1'b0);
        push_word(CMD_ALLOC, 17'd10, 1'b1, 1'b1);
        push_word(CMD_SWEEP, 17'd0, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd200, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd4, 1'b1, 1'b0);
        push_word(CMD_SWEEP, 17'd65536, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd5, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd7, 1'b1, 1'b1);
        push_word(CMD_ALLOC, 17'd0, 1'b0, 1'b0);
        push_word(CMD_ALLOC, 17'd65126, 1'b0, 1'b0);
        push_word(CMD_ALLOC, 17'd216, 1'b0, 1'b0);
        push_word(CMD_ALLOC, 17'd99, 1'b0, 1'b0);
        push_word(CMD_ALLOC, 17'd98, 1'b0, 1'b0);
        push_word(CMD_ALLOC, 17'd65536, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd65536, 1'b1, 1'b0);
        push_word(CMD_SWEEP, 17'd3, 1'b0, 1'b1);
        push_word(CMD_ALLOC, 17'd0, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd65535, 1'b0, 1'b1);
        push_word(CMD_ALLOC, 17'd65536, 1'b0, 1'b0);
        push_word(CMD_SWEEP, 17'd0, 1'b1, 1'b1);
        push_word(CMD_ALLOC, 17'd1, 1'b0, 1'b0);

        for (int p = 0; p < 7; p++) begin
            set_heap(heaps[p]);
            no_idle = (p % 3 == 1);
            eff     = (heaps[p] > HEAP_MAX) ? HEAP_MAX : heaps[p];
            queue_phase(eff, PHASE_SIZE);
        end

        wait_idle();
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        fault_count += outcomes_due.size();
        $display("ran %0d allocation and %0d sweep words over %0d heap sizes",
                 n_alloc, n_sweep_words, n_heaps);
        $display("%0d sweeps closed, %0d table-full and %0d no-fit results, %0d faults",
                 n_sweeps, n_full, n_nofit, fault_count);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
